[hdl/rne_pkg.sv]
// Shared types, letter codes and the microcode program of the Roman numeral encoder.
`default_nettype none

package rne_pkg;

  // Field widths.
  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 7;
  localparam int unsigned PcW    = 5;

  // Largest value that has a Roman numeral.
  localparam logic [ValueW-1:0] MaxValid = 12'd3999;

  // ASCII codes of the numeral letters.
  localparam logic [CharW-1:0] CharI = 7'h49;
  localparam logic [CharW-1:0] CharV = 7'h56;
  localparam logic [CharW-1:0] CharX = 7'h58;
  localparam logic [CharW-1:0] CharL = 7'h4C;
  localparam logic [CharW-1:0] CharC = 7'h43;
  localparam logic [CharW-1:0] CharD = 7'h44;
  localparam logic [CharW-1:0] CharM = 7'h4D;
  localparam logic [CharW-1:0] CharNone = 7'h00;

  // Microcode operations.
  typedef enum logic [1:0] {
    OP_CHECK,   // Screen the loaded value for zero and out of range.
    OP_FIRST,   // Test one denomination and emit its first letter.
    OP_SECOND   // Emit the second letter of a subtractive pair.
  } op_e;

  // One control word of the program.
  typedef struct packed {
    op_e               op;
    logic              pair;
    logic [CharW-1:0]  letter;
    logic [ValueW-1:0] den;
    logic [PcW-1:0]    jmp;
  } uword_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic              load;
    logic              sub;
    logic              emit;
    logic [CharW-1:0]  ch;
    logic              cv;
    logic              last;
    logic              err;
    logic [ValueW-1:0] den;
  } seq_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic zero;
    logic over;
    logic ge;
    logic diff_zero;
    logic out_free;
  } dp_stat_t;

  function automatic uword_t make_uword(op_e op, logic pair, logic [CharW-1:0] letter,
                                        logic [ValueW-1:0] den, logic [PcW-1:0] jmp);
    uword_t w;
    w.op     = op;
    w.pair   = pair;
    w.letter = letter;
    w.den    = den;
    w.jmp    = jmp;
    return w;
  endfunction

  // The program. A first step jumps to its jmp field when the remainder is
  // below the denomination; a second step jumps back to its first step.
  function automatic uword_t ucode_word(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = make_uword(OP_CHECK,  1'b0, CharNone, 12'd0,    5'd1);
      5'd1:    w = make_uword(OP_FIRST,  1'b0, CharM,    12'd1000, 5'd2);
      5'd2:    w = make_uword(OP_FIRST,  1'b1, CharC,    12'd900,  5'd4);
      5'd3:    w = make_uword(OP_SECOND, 1'b0, CharM,    12'd900,  5'd2);
      5'd4:    w = make_uword(OP_FIRST,  1'b0, CharD,    12'd500,  5'd5);
      5'd5:    w = make_uword(OP_FIRST,  1'b1, CharC,    12'd400,  5'd7);
      5'd6:    w = make_uword(OP_SECOND, 1'b0, CharD,    12'd400,  5'd5);
      5'd7:    w = make_uword(OP_FIRST,  1'b0, CharC,    12'd100,  5'd8);
      5'd8:    w = make_uword(OP_FIRST,  1'b1, CharX,    12'd90,   5'd10);
      5'd9:    w = make_uword(OP_SECOND, 1'b0, CharC,    12'd90,   5'd8);
      5'd10:   w = make_uword(OP_FIRST,  1'b0, CharL,    12'd50,   5'd11);
      5'd11:   w = make_uword(OP_FIRST,  1'b1, CharX,    12'd40,   5'd13);
      5'd12:   w = make_uword(OP_SECOND, 1'b0, CharL,    12'd40,   5'd11);
      5'd13:   w = make_uword(OP_FIRST,  1'b0, CharX,    12'd10,   5'd14);
      5'd14:   w = make_uword(OP_FIRST,  1'b1, CharI,    12'd9,    5'd16);
      5'd15:   w = make_uword(OP_SECOND, 1'b0, CharX,    12'd9,    5'd14);
      5'd16:   w = make_uword(OP_FIRST,  1'b0, CharV,    12'd5,    5'd17);
      5'd17:   w = make_uword(OP_FIRST,  1'b1, CharI,    12'd4,    5'd19);
      5'd18:   w = make_uword(OP_SECOND, 1'b0, CharV,    12'd4,    5'd17);
      5'd19:   w = make_uword(OP_FIRST,  1'b0, CharI,    12'd1,    5'd0);
      default: w = make_uword(OP_CHECK,  1'b0, CharNone, 12'd0,    5'd0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/rne_datapath.sv]
// Remainder register, denomination compare and subtract, and the output register.
`default_nettype none

module rne_datapath import rne_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] value_i,
  input  wire seq_ctrl_t         ctrl_i,
  output dp_stat_t               stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [CharW-1:0]       ascii_char_o,
  output logic                   char_valid_o,
  output logic                   last_o,
  output logic                   range_error_o
);

  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW:0]   diff;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q;
  logic              cv_q, last_q, err_q;

  // Compare and subtract against the current denomination.
  assign diff = {1'b0, rem_q} - {1'b0, ctrl_i.den};

  always_comb begin
    stat_o.zero      = (rem_q == '0);
    stat_o.over      = (rem_q > MaxValid);
    stat_o.ge        = ~diff[ValueW];
    stat_o.diff_zero = (diff == '0);
    stat_o.out_free  = ~out_valid_q | out_ready_i;
  end

  // Next remainder.
  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = value_i;
    end else if (ctrl_i.sub) begin
      rem_d = diff[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // Output register: filled on emit, emptied when the receiver takes the item.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      char_q <= ctrl_i.ch;
      cv_q   <= ctrl_i.cv;
      last_q <= ctrl_i.last;
      err_q  <= ctrl_i.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ascii_char_o  = char_q;
  assign char_valid_o  = cv_q;
  assign last_o        = last_q;
  assign range_error_o = err_q;

  // An error item is always a lone, empty, final item.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (last_q && !cv_q))
    else $error("range error item without last or with a letter");

  // A letter item carries one of the seven numeral letters.
  a_letter_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cv_q) |-> (char_q == CharI || char_q == CharV || char_q == CharX ||
                               char_q == CharL || char_q == CharC || char_q == CharD ||
                               char_q == CharM))
    else $error("letter item with a code that is no numeral letter");

  // The remainder only shrinks between loads.
  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.load |=> (rem_q <= $past(rem_q)))
    else $error("remainder grew without a load");

  // Emit is only issued when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> stat_o.out_free)
    else $error("emit into a full output register");

endmodule

`default_nettype wire

[hdl/rne_sequencer.sv]
// Microcode sequencer: step counter, program lookup and branch decisions.
`default_nettype none

module rne_sequencer import rne_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output seq_ctrl_t     ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  logic           busy_q, busy_d;
  uword_t         uw;

  assign uw         = ucode_word(pc_q);
  assign in_ready_o = ~busy_q;

  // Decode the current control word against the datapath status.
  always_comb begin
    pc_d        = pc_q;
    busy_d      = busy_q;
    ctrl_o.load = in_valid_i & ~busy_q;
    ctrl_o.sub  = 1'b0;
    ctrl_o.emit = 1'b0;
    ctrl_o.ch   = CharNone;
    ctrl_o.cv   = 1'b0;
    ctrl_o.last = 1'b0;
    ctrl_o.err  = 1'b0;
    ctrl_o.den  = uw.den;

    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else begin
      case (uw.op)
        OP_CHECK: begin
          if (stat_i.zero || stat_i.over) begin
            if (stat_i.out_free) begin
              ctrl_o.emit = 1'b1;
              ctrl_o.last = 1'b1;
              ctrl_o.err  = stat_i.over;
              busy_d      = 1'b0;
              pc_d        = '0;
            end
          end else begin
            pc_d = uw.jmp;
          end
        end
        OP_FIRST: begin
          if (!stat_i.ge) begin
            pc_d = uw.jmp;
          end else if (stat_i.out_free) begin
            ctrl_o.emit = 1'b1;
            ctrl_o.ch   = uw.letter;
            ctrl_o.cv   = 1'b1;
            if (uw.pair) begin
              pc_d = pc_q + 5'd1;
            end else begin
              ctrl_o.sub  = 1'b1;
              ctrl_o.last = stat_i.diff_zero;
              if (stat_i.diff_zero) begin
                busy_d = 1'b0;
                pc_d   = '0;
              end
            end
          end
        end
        OP_SECOND: begin
          if (stat_i.out_free) begin
            ctrl_o.emit = 1'b1;
            ctrl_o.ch   = uw.letter;
            ctrl_o.cv   = 1'b1;
            ctrl_o.sub  = 1'b1;
            ctrl_o.last = stat_i.diff_zero;
            if (stat_i.diff_zero) begin
              busy_d = 1'b0;
              pc_d   = '0;
            end else begin
              pc_d = uw.jmp;
            end
          end
        end
        default: begin
          busy_d = 1'b0;
          pc_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  // Between items the step counter rests at the program start.
  a_idle_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pc_q == '0))
    else $error("step counter away from start while idle");

  // An accepted item starts the program in the next cycle.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !busy_q) |=> (busy_q && pc_q == '0))
    else $error("accepted item did not start the program");

  // A stalled second-letter step holds its place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_SECOND && !stat_i.out_free) |=> (busy_q && $stable(pc_q)))
    else $error("sequencer moved while the output register was full");

  // The item ends exactly on an emit marked last.
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !busy_d) |-> (ctrl_o.emit && ctrl_o.last))
    else $error("item ended without a final emit");

endmodule

`default_nettype wire

[hdl/roman_numeral_encoder.sv]
// Top level of the Roman numeral encoder: sequencer plus datapath.
//
// Usage: one 12-bit value enters on the input channel (in_valid_i / in_ready_o)
// and leaves as a run of items on the output channel (out_valid_o / out_ready_i),
// one ASCII letter per item, most significant first, last_o on the final one.
// Zero gives one empty item with last_o set; a value above 3999 gives one
// empty item with range_error_o and last_o set.
// Program: a microcoded program runs one step per cycle unless an emitting step
// stalls on a full output register. The range check takes one step, each letter
// one step, and each denomination passed before the one that ends the numeral
// one step; 3888 takes the most steps. Zero or an out-of-range value gets its
// single item from the check step itself; the first letter of a numeral follows
// the check step and any denominations passed before it.
// in_ready_o is high only while no program is running.
// Stalls: results pass through a single output register; while the receiver
// holds out_ready_i low and that register is full, the program freezes on its
// emitting step, so nothing is lost or repeated.
// Reset: rst_ni clears the program state and empties the output register.
`default_nettype none

module roman_numeral_encoder import rne_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CharW-1:0]       ascii_char_o,
  output logic                   char_valid_o,
  output logic                   last_o,
  output logic                   range_error_o
);

  seq_ctrl_t ctrl;
  dp_stat_t  stat;

  rne_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rne_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .ascii_char_o  (ascii_char_o),
    .char_valid_o  (char_valid_o),
    .last_o        (last_o),
    .range_error_o (range_error_o)
  );

endmodule

`default_nettype wire
